### hw/rtl/lspq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// linear scan priority queue. No dependencies.
`default_nettype none

package lspq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned ENTRY_W = PRIO_W + PAY_W;
  localparam int unsigned IN_W    = 48;
  localparam int unsigned OUT_W   = 56;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic shift_mode;
    logic shift_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic sweep_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/linear_scan_priority_queue.sv
// Top level of the linear scan priority queue: joins the controller and the
// datapath. Depends on lspq_pkg, lspq_ctrl, lspq_dp.
//
//   Channel  Direction  Ports                 Contents
//   s_axis   in         tdata[47:0], tuser    one push or pop request
//   m_axis   out        tdata[55:0]           status, popped entry, flags
//
// A push or a pop on an empty queue goes from the idle state straight to the result state.
// A pop over N stored entries scans them through the RAM read port, one per
// cycle, then shifts the entries behind the winner down, one per cycle.
// Reset clears the count and the control state; the entry RAM needs no clearing.
// A new transaction is taken while a finished result still waits on m_axis.
`default_nettype none

module linear_scan_priority_queue
  import lspq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_W-1:0]   s_axis_tdata,  // item_priority[15:0], item_payload[47:16]
  input  wire logic [0:0]        s_axis_tuser,  // op[0]
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [OUT_W-1:0]  m_axis_tdata   // status[1:0], out_priority[17:2],
                                                // out_payload[49:18], is_empty[50],
                                                // is_full[51], zero[55:52]
);

  cmd_t cmd;
  sts_t sts;

  lspq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_pop_i  (s_axis_tuser[0]),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lspq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_pop_i   (s_axis_tuser[0]),
    .in_prio_i  (s_axis_tdata[PRIO_W-1:0]),
    .in_pay_i   (s_axis_tdata[ENTRY_W-1:PRIO_W]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

### hw/rtl/lspq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lspq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lspq_ctrl.sv
// Controller state machine of the priority queue: sequences accept, scan,
// shift and result. Depends on lspq_pkg.
`default_nettype none

module lspq_ctrl
  import lspq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_pop_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_pop_i == OP_POP && !sts_i.empty) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) begin
          cmd_o.shift_start = 1'b1;
          state_d           = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.shift_mode = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lspq_dp.sv
// Datapath of the priority queue: entry RAM, count, scan and shift pointers,
// best-entry tracking and the result register. Depends on lspq_pkg, lspq_ram.
`default_nettype none

module lspq_dp
  import lspq_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  input  wire logic                     in_pop_i,
  input  wire logic signed [PRIO_W-1:0] in_prio_i,
  input  wire logic signed [PAY_W-1:0]  in_pay_i,
  input  wire logic                     out_ready_i,
  output logic                          out_valid_o,
  output logic [OUT_W-1:0]              out_data_o
);

  logic                     in_pop_q;
  logic signed [PRIO_W-1:0] in_prio_q;
  logic signed [PAY_W-1:0]  in_pay_q;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            ptr_q, ptr_d;
  logic [AW-1:0]            ridx_q;
  logic                     rvld_q;
  logic [AW-1:0]            best_idx_q;
  logic signed [PRIO_W-1:0] best_prio_q;
  logic signed [PAY_W-1:0]  best_pay_q;
  logic                     out_vld_q;
  logic [1:0]               out_st_q;
  logic signed [PRIO_W-1:0] out_prio_q;
  logic signed [PAY_W-1:0]  out_pay_q;
  logic                     out_empty_q;
  logic                     out_full_q;

  logic                     full;
  logic                     empty;
  logic                     rd_en;
  logic [ENTRY_W-1:0]       rdata;
  logic signed [PRIO_W-1:0] rprio;
  logic signed [PAY_W-1:0]  rpay;
  logic                     take;
  logic                     sh_we;
  logic                     push_we;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [ENTRY_W-1:0]       wdata;

  assign full    = (cnt_q == CW'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign rd_en   = cmd_i.sweep && (ptr_q < cnt_q);
  assign rprio   = rdata[PRIO_W-1:0];
  assign rpay    = rdata[ENTRY_W-1:PRIO_W];
  assign take    = cmd_i.sweep && !cmd_i.shift_mode && rvld_q &&
                   (ridx_q == '0 || rprio < best_prio_q);
  assign sh_we   = cmd_i.sweep && cmd_i.shift_mode && rvld_q;
  assign push_we = cmd_i.finish && (in_pop_q == OP_PUSH) && !full;
  assign we      = sh_we || push_we;
  assign waddr   = sh_we ? (ridx_q - AW'(1)) : cnt_q[AW-1:0];
  assign wdata   = sh_we ? rdata : {in_pay_q, in_prio_q};

  lspq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(ptr_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign sts_o.empty      = empty;
  assign sts_o.sweep_done = (ptr_q >= cnt_q) && !rvld_q;
  assign sts_o.out_busy   = out_vld_q && !out_ready_i;

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.accept) begin
      ptr_d = '0;
    end else if (cmd_i.shift_start) begin
      ptr_d = CW'(best_idx_q) + CW'(1);
    end else if (rd_en) begin
      ptr_d = ptr_q + CW'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.finish) begin
      if (in_pop_q == OP_PUSH) begin
        if (!full) begin
          cnt_d = cnt_q + CW'(1);
        end
      end else if (!empty) begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ptr_q     <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ptr_q  <= ptr_d;
      rvld_q <= rd_en;
      if (cmd_i.finish) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_pop_q  <= in_pop_i;
      in_prio_q <= in_prio_i;
      in_pay_q  <= in_pay_i;
    end
    if (rd_en) begin
      ridx_q <= ptr_q[AW-1:0];
    end
    if (take) begin
      best_idx_q  <= ridx_q;
      best_prio_q <= rprio;
      best_pay_q  <= rpay;
    end
    if (cmd_i.finish) begin
      out_prio_q  <= '1;
      out_pay_q   <= '1;
      out_empty_q <= (cnt_d == '0);
      out_full_q  <= (cnt_d == CW'(DEPTH));
      if (in_pop_q == OP_PUSH) begin
        out_st_q <= full ? ST_FULL : ST_DONE;
      end else if (empty) begin
        out_st_q <= ST_EMPTY;
      end else begin
        out_st_q   <= ST_DONE;
        out_prio_q <= best_prio_q;
        out_pay_q  <= best_pay_q;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = {4'b0, out_full_q, out_empty_q, out_pay_q, out_prio_q, out_st_q};

endmodule

`default_nettype wire

### verif/lspq_result_monitor.sv
// Result monitor for the linear scan priority queue: follows both stream
// channels, predicts every result from its own copy of the queue and compares.
// Depends on lspq_pkg.

module lspq_result_monitor
  import lspq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  input  wire logic             s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,   // item_priority[15:0], item_payload[47:16]
  input  wire logic [0:0]       s_axis_tuser,   // op[0]
  input  wire logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  input  wire logic [OUT_W-1:0] m_axis_tdata,   // status[1:0], out_priority[17:2],
                                                // out_payload[49:18], is_empty[50],
                                                // is_full[51], zero[55:52]
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    popped_o,
  output int                    full_rejects_o,
  output int                    empty_pops_o
);

  localparam int unsigned FLAG_LSB = 2 + PRIO_W + PAY_W;

  typedef struct packed {
    status_e            status;
    logic [PRIO_W-1:0]  prio;
    logic [PAY_W-1:0]   payload;
    logic               empty;
    logic               full;
  } pq_result_t;

  logic signed [PRIO_W-1:0] held_prio    [DEPTH];
  logic        [PAY_W-1:0]  held_payload [DEPTH];
  int unsigned              held_count;
  pq_result_t               expected_results [$];
  int                       fail_count;
  int                       result_index;
  int                       popped;
  int                       full_rejects;
  int                       empty_pops;

  task automatic report_mismatch(input string field, input logic [31:0] want_val,
                                 input logic [31:0] got_val);
    $display("lspq mismatch: %s of result %0d, expected %h, got %h",
             field, result_index, want_val, got_val);
    fail_count++;
  endtask

  // Applies one accepted request to the shadow queue and queues its result.
  task automatic apply_request(input logic op, input logic signed [PRIO_W-1:0] prio,
                               input logic [PAY_W-1:0] payload);
    pq_result_t  res;
    int unsigned best;
    res.status  = ST_DONE;
    res.prio    = '1;
    res.payload = '1;
    if (op == OP_PUSH) begin
      if (held_count >= DEPTH) begin
        res.status = ST_FULL;
        full_rejects++;
      end else begin
        held_prio[held_count]    = prio;
        held_payload[held_count] = payload;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
      empty_pops++;
    end else begin
      // Strict comparison keeps the oldest entry among equal priorities.
      best = 0;
      for (int unsigned i = 1; i < held_count; i++) begin
        if (held_prio[i] < held_prio[best]) begin
          best = i;
        end
      end
      res.prio    = held_prio[best];
      res.payload = held_payload[best];
      for (int unsigned i = best; i + 1 < held_count; i++) begin
        held_prio[i]    = held_prio[i+1];
        held_payload[i] = held_payload[i+1];
      end
      held_count--;
      popped++;
    end
    res.empty = (held_count == 0);
    res.full  = (held_count == DEPTH);
    expected_results.push_back(res);
  endtask

  task automatic check_result(input logic [OUT_W-1:0] word);
    pq_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("transaction with nothing pending", '0, word[31:0]);
    end else begin
      want = expected_results.pop_front();
      if (word[1:0] !== want.status) begin
        report_mismatch("status", 32'(want.status), 32'(word[1:0]));
      end
      if (word[2 +: PRIO_W] !== want.prio) begin
        report_mismatch("out_priority", 32'(want.prio), 32'(word[2 +: PRIO_W]));
      end
      if (word[2+PRIO_W +: PAY_W] !== want.payload) begin
        report_mismatch("out_payload", want.payload, word[2+PRIO_W +: PAY_W]);
      end
      if (word[FLAG_LSB] !== want.empty) begin
        report_mismatch("is_empty", 32'(want.empty), 32'(word[FLAG_LSB]));
      end
      if (word[FLAG_LSB+1] !== want.full) begin
        report_mismatch("is_full", 32'(want.full), 32'(word[FLAG_LSB+1]));
      end
      if (word[OUT_W-1:FLAG_LSB+2] !== '0) begin
        report_mismatch("padding", '0, 32'(word[OUT_W-1:FLAG_LSB+2]));
      end
    end
    result_index++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(s_axis_tuser[0], s_axis_tdata[PRIO_W-1:0],
                      s_axis_tdata[PRIO_W +: PAY_W]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
      end
    end
    fail_count_o   <= fail_count;
    pending_o      <= expected_results.size();
    popped_o       <= popped;
    full_rejects_o <= full_rejects;
    empty_pops_o   <= empty_pops;
  end

endmodule

### verif/tb_linear_scan_priority_queue.sv
// Testbench top for the linear scan priority queue: drives push and pop
// requests with random gaps and stalls and gives the verdict.
// Depends on lspq_pkg, linear_scan_priority_queue and lspq_result_monitor.

module tb_linear_scan_priority_queue;
  import lspq_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_TAIL   = 200;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum int {
    PRIO_ANY,
    PRIO_CLUSTERED,
    PRIO_CORNER
  } prio_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // item_priority[15:0], item_payload[47:16]
  logic [0:0]       s_axis_tuser;   // op[0]
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;   // status[1:0], out_priority[17:2],
                                    // out_payload[49:18], is_empty[50],
                                    // is_full[51], zero[55:52]

  int   fail_count;
  int   pending;
  int   popped;
  int   full_rejects;
  int   empty_pops;
  int   sent = 0;
  int   cycles = 0;
  int   stall_left = 0;
  logic idle_on = 1'b0;

  linear_scan_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lspq_result_monitor monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .popped_o       (popped),
    .full_rejects_o (full_rejects),
    .empty_pops_o   (empty_pops)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding.", pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [PRIO_W-1:0] random_priority(input prio_mode_e mode);
    logic [PRIO_W-1:0] corner [5];
    logic [PRIO_W-1:0] near_zero;
    corner    = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h7FFF};
    near_zero = PRIO_W'($urandom_range(0, 4));
    case (mode)
      PRIO_ANY: begin
        return PRIO_W'($urandom);
      end
      PRIO_CLUSTERED: begin
        return near_zero - 16'd2;
      end
      default: begin
        return corner[$urandom_range(0, 4)];
      end
    endcase
  endfunction

  // Holds one request on s_axis until its transaction completes.
  task automatic send_request(input logic op, input logic [PRIO_W-1:0] prio,
                              input logic [PAY_W-1:0] payload);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {payload, prio};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  initial begin
    int         push_pct;
    int         phase_len;
    int         done;
    prio_mode_e mode;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_PUSH;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pop on an empty queue, then priority extremes with a tie on the most
    // urgent value, fill to full, a refused push and pops that resolve the tie.
    send_request(OP_POP, '0, '0);
    send_request(OP_PUSH, 16'h7FFF, 32'h0000_0000);
    send_request(OP_PUSH, 16'h8000, 32'hFFFF_FFFF);
    send_request(OP_PUSH, 16'h0000, 32'h8000_0000);
    send_request(OP_PUSH, 16'hFFFF, 32'h7FFF_FFFF);
    send_request(OP_PUSH, 16'h8000, 32'h1234_5678);
    for (int i = 5; i < DEPTH; i++) begin
      send_request(OP_PUSH, PRIO_W'($urandom), $urandom);
    end
    send_request(OP_PUSH, 16'h8000, 32'hFFFF_FFFF);
    repeat (7) send_request(OP_POP, PRIO_W'($urandom), $urandom);

    // Phases lean toward filling or draining so that both ends are reached often.
    done = 0;
    while (done < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 90);
      case ($urandom_range(0, 2))
        0:       push_pct = 20;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      mode = prio_mode_e'($urandom_range(0, 2));
      idle_on <= (RANDOM_ITEMS - done > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < phase_len && done < RANDOM_ITEMS; k++) begin
        send_request(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
                     random_priority(mode), $urandom);
        done++;
      end
    end

    s_axis_tvalid <= 1'b0;
    idle_on       <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Issued %0d requests: %0d entries popped, %0d pops on an empty queue,",
             sent, popped, empty_pops);
    $display("%0d pushes refused while full, %0d mismatches.", full_rejects, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
